FILE: rtl/tcw_pkg.sv
package tcw_pkg;

  localparam int KIND_WIDTH      = 2;
  localparam int ACK_WIDTH       = 16;
  localparam int ROUND_WIDTH     = 16;
  localparam int NOTE_WIDTH      = 3;
  localparam int CFG_DATA_WIDTH  = 24;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int LIMIT_WIDTH     = 4;

  // threshold reset values in whole window units
  localparam int INIT_THR_UNITS = 16;
  localparam int MIN_THR_UNITS  = 2;

  localparam logic [LIMIT_WIDTH-1:0] DUP_LIMIT_RESET = 4'd3;
  localparam logic [LIMIT_WIDTH-1:0] DUP_COUNT_MAX   = 4'd15;

  localparam logic [KIND_WIDTH-1:0] KIND_NEW_ACK = 2'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_DUP_ACK = 2'd1;

  localparam logic [NOTE_WIDTH-1:0] NOTE_SLOW_START = 3'd0;
  localparam logic [NOTE_WIDTH-1:0] NOTE_ADDITIVE   = 3'd1;
  localparam logic [NOTE_WIDTH-1:0] NOTE_WAITING    = 3'd2;
  localparam logic [NOTE_WIDTH-1:0] NOTE_DUP_RESET  = 3'd3;
  localparam logic [NOTE_WIDTH-1:0] NOTE_TIMEOUT    = 3'd4;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INIT_THR  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_THR   = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DUP_LIMIT = 2'd2;

  typedef struct packed {
    logic load;
    logic step;
    logic apply;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/tcw_event_if.sv
interface tcw_event_if;
  logic                             valid;
  logic                             ready;
  logic [tcw_pkg::KIND_WIDTH-1:0]   kind;
  logic [tcw_pkg::ACK_WIDTH-1:0]    ack_number;

  modport source (output valid, kind, ack_number, input ready);
  modport sink (input valid, kind, ack_number, output ready);
endinterface

FILE: rtl/tcw_result_if.sv
interface tcw_result_if #(
  parameter int WINDOW_WIDTH = 24
);
  logic                              valid;
  logic                              ready;
  logic [tcw_pkg::ROUND_WIDTH-1:0]   round_count;
  logic [WINDOW_WIDTH-1:0]           window;
  logic [WINDOW_WIDTH-1:0]           threshold;
  logic                              phase;
  logic [tcw_pkg::NOTE_WIDTH-1:0]    note;
  logic [tcw_pkg::ACK_WIDTH-1:0]     ack_echo;

  modport source (output valid, round_count, window, threshold, phase, note, ack_echo,
                  input ready);
  modport sink (input valid, round_count, window, threshold, phase, note, ack_echo,
                output ready);
endinterface

FILE: rtl/tcp_tahoe_congestion_window_core.sv
// a new ack in congestion avoidance goes from acceptance to the result register
// through the bit-serial reciprocal divider (one quotient bit per cycle); every other
// event skips the divider and goes straight to the update
// a new event is taken only once the last one has left the update; a result still waiting
// in the result register holds the update and the input side
// reset: synchronous rst sets window 1.0, threshold 16.0, slow start, counts zero and
// the configuration registers to their defaults
module tcp_tahoe_congestion_window_core #(
  parameter int FRAC_BITS    = 16,
  parameter int WINDOW_WIDTH = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  tcw_event_if.sink                             evt,
  tcw_result_if.source                          res,
  input  logic                                  cfg_wr_en,
  input  logic [tcw_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [tcw_pkg::CFG_DATA_WIDTH-1:0]    cfg_wr_data
);

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t status;

  logic                            out_valid;
  logic [tcw_pkg::ROUND_WIDTH-1:0] out_round_count;
  logic [WINDOW_WIDTH-1:0]         out_window;
  logic [WINDOW_WIDTH-1:0]         out_threshold;
  logic                            out_phase;
  logic [tcw_pkg::NOTE_WIDTH-1:0]  out_note;
  logic [tcw_pkg::ACK_WIDTH-1:0]   out_ack_echo;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (evt.valid),
    .in_ready (evt.ready),
    .status   (status),
    .cmd      (cmd)
  );

  tcw_dpath #(
    .FRAC_BITS    (FRAC_BITS),
    .WINDOW_WIDTH (WINDOW_WIDTH)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .in_kind         (evt.kind),
    .in_ack          (evt.ack_number),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_ready       (res.ready),
    .out_round_count (out_round_count),
    .out_window      (out_window),
    .out_threshold   (out_threshold),
    .out_phase       (out_phase),
    .out_note        (out_note),
    .out_ack_echo    (out_ack_echo)
  );

  assign res.valid       = out_valid;
  assign res.round_count = out_round_count;
  assign res.window      = out_window;
  assign res.threshold   = out_threshold;
  assign res.phase       = out_phase;
  assign res.note        = out_note;
  assign res.ack_echo    = out_ack_echo;

endmodule

FILE: rtl/tcw_ctrl.sv
module tcw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tcw_pkg::status_t status,
  output tcw_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_DIV   = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = status.need_div ? S_DIV : S_APPLY;
        end
      end
      S_DIV: begin
        if (status.div_last) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign cmd.load  = in_ready && in_valid;
  assign cmd.step  = (state == S_DIV);
  assign cmd.apply = (state == S_APPLY) && status.out_free;

  a_apply_then_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> in_ready)
    else $error("controller did not return to idle after update");

endmodule

FILE: rtl/tcw_div.sv
module tcw_div #(
  parameter int FRAC_BITS    = 16,
  parameter int WINDOW_WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  logic                     step,
  input  logic [WINDOW_WIDTH-1:0]  divisor,
  output logic [2*FRAC_BITS:0]     quotient,
  output logic                     last
);

  localparam int QW = 2 * FRAC_BITS + 1;
  localparam int CW = $clog2(QW);
  localparam logic [CW-1:0] CNT_TOP = CW'(QW - 1);

  logic [WINDOW_WIDTH-1:0] rem, rem_next;
  logic [WINDOW_WIDTH:0]   trial;
  logic [WINDOW_WIDTH:0]   diff;
  logic                    take;
  logic [CW-1:0]           cnt;

  // numerator is a single one at its top bit
  assign trial = {rem, (cnt == CNT_TOP)};
  assign take  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};
  assign rem_next = take ? diff[WINDOW_WIDTH-1:0] : trial[WINDOW_WIDTH-1:0];
  assign last = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= CNT_TOP;
    end else if (step) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem      <= '0;
      quotient <= '0;
    end else if (step) begin
      rem      <= rem_next;
      quotient <= {quotient[QW-2:0], take};
    end
  end

endmodule

FILE: rtl/tcw_dpath.sv
module tcw_dpath #(
  parameter int FRAC_BITS    = 16,
  parameter int WINDOW_WIDTH = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tcw_pkg::cmd_t                         cmd,
  output tcw_pkg::status_t                      status,
  input  logic [tcw_pkg::KIND_WIDTH-1:0]        in_kind,
  input  logic [tcw_pkg::ACK_WIDTH-1:0]         in_ack,
  input  logic                                  cfg_wr_en,
  input  logic [tcw_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [tcw_pkg::CFG_DATA_WIDTH-1:0]    cfg_wr_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [tcw_pkg::ROUND_WIDTH-1:0]       out_round_count,
  output logic [WINDOW_WIDTH-1:0]               out_window,
  output logic [WINDOW_WIDTH-1:0]               out_threshold,
  output logic                                  out_phase,
  output logic [tcw_pkg::NOTE_WIDTH-1:0]        out_note,
  output logic [tcw_pkg::ACK_WIDTH-1:0]         out_ack_echo
);

  localparam int WW = WINDOW_WIDTH;
  localparam int QW = 2 * FRAC_BITS + 1;
  localparam int SW = ((WW > QW) ? WW : QW) + 1;
  localparam int XW = (WW > tcw_pkg::CFG_DATA_WIDTH) ? WW : tcw_pkg::CFG_DATA_WIDTH;
  localparam int LW = tcw_pkg::LIMIT_WIDTH;

  localparam logic [WW-1:0] WIN_ONE  = WW'(64'd1 << FRAC_BITS);
  localparam logic [WW-1:0] INIT_THR = WW'(64'(tcw_pkg::INIT_THR_UNITS) << FRAC_BITS);
  localparam logic [WW-1:0] MIN_THR  = WW'(64'(tcw_pkg::MIN_THR_UNITS) << FRAC_BITS);

  logic [WW-1:0]                     cwnd, ssthresh;
  logic                              phase;
  logic [LW-1:0]                     dup_count;
  logic [tcw_pkg::ROUND_WIDTH-1:0]   round;
  logic [WW-1:0]                     min_thr;
  logic [LW-1:0]                     dup_limit;

  logic [tcw_pkg::KIND_WIDTH-1:0]    kind_q;
  logic [tcw_pkg::ACK_WIDTH-1:0]     ack_q;

  logic [QW-1:0]                     quotient;
  logic                              div_last;

  logic [XW-1:0]                     cfg_ext;
  logic [SW-1:0]                     inc_ext, sum;
  logic [WW-1:0]                     grown, half, loss_thr;
  logic [LW-1:0]                     limit, dup_inc;

  logic [WW-1:0]                     cwnd_next, ssthresh_next;
  logic                              phase_next;
  logic [LW-1:0]                     dup_count_next;
  logic [tcw_pkg::ROUND_WIDTH-1:0]   round_next;
  logic [tcw_pkg::NOTE_WIDTH-1:0]    note_next;
  logic [tcw_pkg::ACK_WIDTH-1:0]     echo_next;

  tcw_div #(
    .FRAC_BITS    (FRAC_BITS),
    .WINDOW_WIDTH (WINDOW_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (cmd.load),
    .step     (cmd.step),
    .divisor  (cwnd),
    .quotient (quotient),
    .last     (div_last)
  );

  assign status.need_div = (in_kind == tcw_pkg::KIND_NEW_ACK) && phase;
  assign status.div_last = div_last;
  assign status.out_free = !out_valid || out_ready;

  assign cfg_ext = XW'(cfg_wr_data);

  // saturating window growth
  always_comb begin
    if (!phase) begin
      inc_ext = SW'(WIN_ONE);
    end else if (cwnd == '0) begin
      inc_ext = '0;
    end else begin
      inc_ext = SW'(quotient);
    end
    sum   = SW'(cwnd) + inc_ext;
    grown = (|sum[SW-1:WW]) ? '1 : sum[WW-1:0];
  end

  assign half     = cwnd >> 1;
  assign loss_thr = (half < min_thr) ? min_thr : half;
  assign limit    = (dup_limit == '0) ? LW'(1) : dup_limit;
  assign dup_inc  = (dup_count != tcw_pkg::DUP_COUNT_MAX) ? dup_count + 1'b1 : dup_count;

  always_comb begin
    round_next     = round + 1'b1;
    cwnd_next      = cwnd;
    ssthresh_next  = ssthresh;
    phase_next     = phase;
    dup_count_next = dup_count;
    echo_next      = ack_q;
    note_next      = tcw_pkg::NOTE_TIMEOUT;
    case (kind_q)
      tcw_pkg::KIND_NEW_ACK: begin
        dup_count_next = '0;
        cwnd_next      = grown;
        if (!phase) begin
          phase_next = (grown >= ssthresh);
          note_next  = tcw_pkg::NOTE_SLOW_START;
        end else begin
          note_next  = tcw_pkg::NOTE_ADDITIVE;
        end
      end
      tcw_pkg::KIND_DUP_ACK: begin
        if (dup_inc < limit) begin
          dup_count_next = dup_inc;
          note_next      = tcw_pkg::NOTE_WAITING;
        end else begin
          ssthresh_next  = loss_thr;
          cwnd_next      = WIN_ONE;
          phase_next     = 1'b0;
          dup_count_next = '0;
          note_next      = tcw_pkg::NOTE_DUP_RESET;
        end
      end
      default: begin
        ssthresh_next  = loss_thr;
        cwnd_next      = WIN_ONE;
        phase_next     = 1'b0;
        dup_count_next = '0;
        echo_next      = '0;
        note_next      = tcw_pkg::NOTE_TIMEOUT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cwnd      <= WIN_ONE;
      ssthresh  <= INIT_THR;
      phase     <= 1'b0;
      dup_count <= '0;
      round     <= '0;
      min_thr   <= MIN_THR;
      dup_limit <= tcw_pkg::DUP_LIMIT_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cmd.apply) begin
        cwnd      <= cwnd_next;
        ssthresh  <= ssthresh_next;
        phase     <= phase_next;
        dup_count <= dup_count_next;
        round     <= round_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          tcw_pkg::CFG_INIT_THR: begin
            ssthresh <= cfg_ext[WW-1:0];
          end
          tcw_pkg::CFG_MIN_THR: begin
            min_thr <= cfg_ext[WW-1:0];
          end
          tcw_pkg::CFG_DUP_LIMIT: begin
            dup_limit <= cfg_wr_data[LW-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= in_kind;
      ack_q  <= in_ack;
    end
    if (cmd.apply) begin
      out_round_count <= round_next;
      out_window      <= cwnd_next;
      out_threshold   <= ssthresh_next;
      out_phase       <= phase_next;
      out_note        <= note_next;
      out_ack_echo    <= echo_next;
    end
  end

  a_valid_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.apply))
    else $error("result appeared without an update");

  a_divide_in_avoidance: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> phase && (kind_q == tcw_pkg::KIND_NEW_ACK))
    else $error("divider running outside congestion avoidance");

  a_loss_resets_window: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((out_note == tcw_pkg::NOTE_DUP_RESET) || (out_note == tcw_pkg::NOTE_TIMEOUT))
      |-> !out_phase && (out_window == WIN_ONE))
    else $error("loss result without window reset");

  a_additive_in_avoidance: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_note == tcw_pkg::NOTE_ADDITIVE) |-> out_phase)
    else $error("additive increase reported outside avoidance");

endmodule

FILE: verif/tcp_tahoe_congestion_window_core_test.sv
module tcp_tahoe_congestion_window_core_test;
  import tcw_pkg::*;

  localparam int FRAC_W = 16;
  localparam int WIN_W = 24;
  localparam int SLOW_LATENCY = 2 * FRAC_W + 3;
  localparam logic [KIND_WIDTH-1:0] KIND_TIMEOUT = 2'd2;
  localparam logic [KIND_WIDTH-1:0] KIND_SPARE = 2'd3;
  localparam logic PHASE_SLOW_START = 1'b0;
  localparam logic PHASE_AVOIDANCE = 1'b1;
  localparam logic [WIN_W-1:0] WIN_ONE = WIN_W'(64'd1 << FRAC_W);
  localparam logic [WIN_W-1:0] WIN_MAX = '1;

  typedef struct packed {
    logic [ROUND_WIDTH-1:0] round_count;
    logic [WIN_W-1:0]       window;
    logic [WIN_W-1:0]       threshold;
    logic                   phase;
    logic [NOTE_WIDTH-1:0]  note;
    logic [ACK_WIDTH-1:0]   ack_echo;
  } outcome_t;

  class tahoe_scoreboard;
    logic [WIN_W-1:0] cwnd;
    logic [WIN_W-1:0] ssthresh;
    logic [WIN_W-1:0] init_thr;
    logic [WIN_W-1:0] min_thr;
    logic phase_bit;
    logic [LIMIT_WIDTH-1:0] dup_count;
    logic [LIMIT_WIDTH-1:0] dup_limit;
    logic [ROUND_WIDTH-1:0] rounds;
    outcome_t awaited[$];
    int failures;

    function new();
      init_thr = WIN_W'(64'(INIT_THR_UNITS) << FRAC_W);
      min_thr = WIN_W'(64'(MIN_THR_UNITS) << FRAC_W);
      dup_limit = DUP_LIMIT_RESET;
      cwnd = WIN_ONE;
      ssthresh = init_thr;
      phase_bit = PHASE_SLOW_START;
      dup_count = '0;
      rounds = '0;
      failures = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_WIDTH-1:0] index,
                                 logic [CFG_DATA_WIDTH-1:0] value);
      case (index)
        CFG_INIT_THR: begin
          init_thr = value;
          ssthresh = value;
        end
        CFG_MIN_THR: min_thr = value;
        CFG_DUP_LIMIT: dup_limit = value[LIMIT_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    function logic [WIN_W-1:0] grow(logic [63:0] amount);
      logic [63:0] sum;
      sum = 64'(cwnd) + amount;
      return (sum > 64'(WIN_MAX)) ? WIN_MAX : sum[WIN_W-1:0];
    endfunction

    function void cut_window();
      logic [WIN_W-1:0] half;
      half = cwnd >> 1;
      ssthresh = (half < min_thr) ? min_thr : half;
      cwnd = WIN_ONE;
      phase_bit = PHASE_SLOW_START;
      dup_count = '0;
    endfunction

    function void note_event(logic [KIND_WIDTH-1:0] kind, logic [ACK_WIDTH-1:0] ack);
      outcome_t want;
      logic [LIMIT_WIDTH-1:0] limit;
      rounds = rounds + 1'b1;
      want.ack_echo = ack;
      limit = (dup_limit == '0) ? 4'd1 : dup_limit;
      if (kind == KIND_NEW_ACK) begin
        dup_count = '0;
        if (phase_bit == PHASE_SLOW_START) begin
          cwnd = grow(64'(WIN_ONE));
          if (cwnd >= ssthresh) phase_bit = PHASE_AVOIDANCE;
          want.note = NOTE_SLOW_START;
        end else begin
          // reciprocal increase, 1/window in the same fixed point
          cwnd = grow((64'd1 << (2 * FRAC_W)) / 64'(cwnd));
          want.note = NOTE_ADDITIVE;
        end
      end else if (kind == KIND_DUP_ACK) begin
        if (dup_count < DUP_COUNT_MAX) dup_count = dup_count + 1'b1;
        if (dup_count < limit) begin
          want.note = NOTE_WAITING;
        end else begin
          cut_window();
          want.note = NOTE_DUP_RESET;
        end
      end else begin
        cut_window();
        want.note = NOTE_TIMEOUT;
        want.ack_echo = '0;
      end
      want.round_count = rounds;
      want.window = cwnd;
      want.threshold = ssthresh;
      want.phase = phase_bit;
      awaited.push_back(want);
    endfunction

    function string show(outcome_t r);
      return $sformatf("round %0d window %h threshold %h phase %0d note %0d ack %h",
                       r.round_count, r.window, r.threshold, r.phase, r.note, r.ack_echo);
    endfunction

    function void complain(string what);
      failures++;
      if (failures <= 10) $display("%s", what);
    endfunction

    function void check_result(outcome_t seen);
      outcome_t want;
      if (awaited.size() == 0) begin
        complain({"unexpected transaction: ", show(seen)});
      end else begin
        want = awaited.pop_front();
        if (seen.round_count !== want.round_count || seen.window !== want.window ||
            seen.threshold !== want.threshold || seen.phase !== want.phase ||
            seen.note !== want.note || seen.ack_echo !== want.ack_echo)
          complain({"mismatch: expected ", show(want), "; got ", show(seen)});
      end
    endfunction

    function void close();
      if (awaited.size() != 0)
        complain($sformatf("%0d transactions never arrived", awaited.size()));
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_wr_data;
  int idle_pct;
  int stall_pct;
  int hold_request;
  logic [ACK_WIDTH-1:0] next_ack;
  outcome_t seen;
  tahoe_scoreboard board = new();

  tcw_event_if evt_bus ();
  tcw_result_if #(.WINDOW_WIDTH(WIN_W)) res_bus ();

  tcp_tahoe_congestion_window_core #(
    .FRAC_BITS(FRAC_W),
    .WINDOW_WIDTH(WIN_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .evt(evt_bus),
    .res(res_bus),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready) begin
      seen.round_count = res_bus.round_count;
      seen.window = res_bus.window;
      seen.threshold = res_bus.threshold;
      seen.phase = res_bus.phase;
      seen.note = res_bus.note;
      seen.ack_echo = res_bus.ack_echo;
      board.check_result(seen);
    end
  end

  task automatic send_event(input logic [KIND_WIDTH-1:0] kind,
                            input logic [ACK_WIDTH-1:0] ack);
    if ($urandom_range(99) < idle_pct) begin
      evt_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    evt_bus.valid <= 1'b1;
    evt_bus.kind <= kind;
    evt_bus.ack_number <= ack;
    do @(posedge clk); while (!evt_bus.ready);
    board.note_event(kind, ack);
  endtask

  task automatic send_new_ack();
    next_ack = next_ack + ACK_WIDTH'($urandom_range(1460, 1));
    send_event(KIND_NEW_ACK, next_ack);
  endtask

  task automatic wait_for_results();
    evt_bus.valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_WIDTH-1:0] init_v,
                                input logic [CFG_DATA_WIDTH-1:0] min_v,
                                input logic [CFG_DATA_WIDTH-1:0] limit_v);
    logic [CFG_DATA_WIDTH-1:0] values [3];
    logic [CFG_INDEX_WIDTH-1:0] regs [3];
    values = '{init_v, min_v, limit_v};
    regs = '{CFG_INIT_THR, CFG_MIN_THR, CFG_DUP_LIMIT};
    for (int i = 0; i < 3; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[i];
      cfg_wr_data <= values[i];
      @(posedge clk);
      board.write_register(regs[i], values[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // mostly in-order ack streams with dup bursts, some losses and noise
  task automatic run_traffic(input int count, input int loss_pct, input int dup_pct,
                             input int noise_pct, input int dup_run);
    int sent;
    int pick;
    int run;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < loss_pct) begin
        send_event(($urandom_range(5) == 0) ? KIND_SPARE : KIND_TIMEOUT,
                   ACK_WIDTH'($urandom));
        sent++;
      end else if (pick < loss_pct + dup_pct) begin
        run = $urandom_range(dup_run, 1);
        repeat (run) begin
          send_event(KIND_DUP_ACK,
                     ($urandom_range(9) == 0) ? ACK_WIDTH'($urandom) : next_ack);
          sent++;
        end
      end else if (pick < loss_pct + dup_pct + noise_pct) begin
        send_event(KIND_WIDTH'($urandom_range(3)), ACK_WIDTH'($urandom));
        sent++;
      end else begin
        send_new_ack();
        sent++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wr_data = '0;
    evt_bus.valid = 1'b0;
    evt_bus.kind = '0;
    evt_bus.ack_number = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_request = 0;
    next_ack = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // defaults after reset
    send_event(KIND_NEW_ACK, 16'h0000);
    send_event(KIND_NEW_ACK, 16'hFFFF);
    repeat (3) send_event(KIND_DUP_ACK, 16'hFFFF);
    send_event(KIND_DUP_ACK, 16'h8000);
    send_event(KIND_NEW_ACK, 16'h0001);
    repeat (2) send_event(KIND_DUP_ACK, 16'h0001);
    send_event(KIND_TIMEOUT, 16'hFFFF);
    send_event(KIND_SPARE, 16'h5A5A);
    repeat (10) send_new_ack();
    wait_for_results();

    // climb to window saturation
    apply_settings(24'hFFFFFF, 24'hFFFFFF, {20'($urandom), 4'd15});
    run_traffic(400, 0, 3, 0, 14);
    send_event(KIND_TIMEOUT, ACK_WIDTH'($urandom));
    wait_for_results();

    idle_pct = 87;
    apply_settings(24'h000000, 24'h000000, {20'($urandom), 4'd0});
    run_traffic(200, 4, 15, 5, 4);
    wait_for_results();

    idle_pct = 0;
    stall_pct = 87;
    apply_settings(24'($urandom_range(24'h080000)), 24'($urandom_range(24'h040000)),
                   24'($urandom_range(15, 1)));
    run_traffic(250, 3, 12, 4, 6);
    wait_for_results();

    idle_pct = 28;
    stall_pct = 28;
    apply_settings(24'(INIT_THR_UNITS << FRAC_W), 24'(MIN_THR_UNITS << FRAC_W),
                   24'(DUP_LIMIT_RESET));
    run_traffic(250, 3, 12, 4, 4);
    wait_for_results();

    // long receiver hold while the sender keeps offering
    idle_pct = 0;
    stall_pct = 0;
    apply_settings(24'h040000, 24'h010000, 24'd2);
    hold_request = 300;
    run_traffic(150, 3, 10, 3, 3);
    wait_for_results();

    apply_settings(24'($urandom), 24'($urandom), 24'($urandom));
    repeat (5) begin
      idle_pct = ($urandom_range(1) == 0) ? 0 : 87;
      stall_pct = ($urandom_range(1) == 0) ? 0 : 87;
      run_traffic(50, 3, 12, 4, 8);
    end
    wait_for_results();

    repeat (SLOW_LATENCY + 5) @(posedge clk);
    board.close();
    if (board.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tcw_pkg.sv
rtl/tcw_event_if.sv
rtl/tcw_result_if.sv
rtl/tcw_ctrl.sv
rtl/tcw_div.sv
rtl/tcw_dpath.sv
rtl/tcp_tahoe_congestion_window_core.sv
verif/tcp_tahoe_congestion_window_core_test.sv
